[src/dmwbc_pkg.sv]
// Shared types, codes and helpers for the direct-mapped write-back cache.
// Used by the controller, the datapath and the top level.
`default_nettype none

package dmwbc_pkg;

   // Default geometry, handed down from the top level.
   localparam int DEF_ADDRESS_BITS = 16;
   localparam int DEF_LINE_COUNT   = 32;

   // Fixed field widths.
   localparam int WORD_BITS  = 16;
   localparam int COUNT_BITS = 32;

   // Operation codes.
   localparam logic [1:0] FUNC_READ    = 2'd0;
   localparam logic [1:0] FUNC_WRITE   = 2'd1;
   localparam logic [1:0] FUNC_PRELOAD = 2'd2;

   // One request item.
   typedef struct packed {
      logic [1:0]           func;
      logic [WORD_BITS-1:0] access_address;
      logic [WORD_BITS-1:0] write_data;
   } req_payload_type;

   // One response item.
   typedef struct packed {
      logic [WORD_BITS-1:0]  read_data;
      logic                  was_hit;
      logic                  did_writeback;
      logic [WORD_BITS-1:0]  writeback_address;
      logic [WORD_BITS-1:0]  writeback_data;
      logic                  did_fill;
      logic [COUNT_BITS-1:0] hit_total;
      logic [COUNT_BITS-1:0] miss_total;
      logic [COUNT_BITS-1:0] backing_read_total;
      logic [COUNT_BITS-1:0] backing_write_total;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic clear_write;
      logic line_capture;
      logic backing_writeback;
      logic backing_fill_read;
      logic preload;
      logic line_fill;
      logic line_update;
      logic respond;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;
      logic is_write;
      logic is_preload;
      logic hit;
      logic victim_dirty;
      logic word_differs;
      logic clear_done;
      logic rsp_free;
   } dp_status_type;

   // Saturating increment of a statistics counter.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] value,
                                                     input logic enable);
      if (enable && (value != '1)) begin
         return value + COUNT_BITS'(1);
      end
      return value;
   endfunction

endpackage

`default_nettype wire

[src/dmwbc_chan_if.sv]
// Valid/ready channel carrying one payload item per transfer.
// The payload type comes from dmwbc_pkg at the point of instantiation.
`default_nettype none

interface dmwbc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/dmwbc_ram.sv]
// Generic single-port RAM with a registered, read-first data output.
// Stands alone; used for the line store and the backing store.
`default_nettype none

module dmwbc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access per cycle; the read returns the old contents.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[addr] <= write_data;
      end
      read_data <= mem_ff[addr];
   end

endmodule

`default_nettype wire

[src/dmwbc_ctrl.sv]
// Sequencing state machine for the cache: clearing pass, lookup, write-back,
// fill, line update, preload and response. Depends on dmwbc_pkg command/status types.
`default_nettype none

module dmwbc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire dmwbc_pkg::dp_status_type status,
   output dmwbc_pkg::dp_cmd_type         cmd
);
   import dmwbc_pkg::*;

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_IDX_MUL   = 4'd2;
   localparam logic [3:0] ST_IDX_SCALE = 4'd3;
   localparam logic [3:0] ST_IDX_FIX   = 4'd4;
   localparam logic [3:0] ST_LINE_RD   = 4'd5;
   localparam logic [3:0] ST_LINE_CHK  = 4'd6;
   localparam logic [3:0] ST_DECIDE    = 4'd7;
   localparam logic [3:0] ST_WRITEBACK = 4'd8;
   localparam logic [3:0] ST_FILL_RD   = 4'd9;
   localparam logic [3:0] ST_FILL_WAIT = 4'd10;
   localparam logic [3:0] ST_UPDATE    = 4'd11;
   localparam logic [3:0] ST_PRELOAD   = 4'd12;
   localparam logic [3:0] ST_RESPOND   = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_IDX_MUL;
            end
         end
         ST_IDX_MUL: begin
            if (status.is_read || status.is_write) begin
               state_in = ST_IDX_SCALE;
            end else if (status.is_preload) begin
               state_in = ST_PRELOAD;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_IDX_SCALE: state_in = ST_IDX_FIX;
         ST_IDX_FIX:   state_in = ST_LINE_RD;
         ST_LINE_RD:   state_in = ST_LINE_CHK;
         ST_LINE_CHK: begin
            cmd.line_capture = 1'b1;
            state_in         = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.hit) begin
               if (status.is_write && status.word_differs) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_RESPOND;
               end
            end else if (status.victim_dirty) begin
               state_in = ST_WRITEBACK;
            end else if (status.is_read) begin
               state_in = ST_FILL_RD;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_WRITEBACK: begin
            cmd.backing_writeback = 1'b1;
            state_in = status.is_read ? ST_FILL_RD : ST_UPDATE;
         end
         ST_FILL_RD: begin
            cmd.backing_fill_read = 1'b1;
            state_in              = ST_FILL_WAIT;
         end
         ST_FILL_WAIT: begin
            cmd.line_fill = 1'b1;
            state_in      = ST_RESPOND;
         end
         ST_UPDATE: begin
            cmd.line_update = 1'b1;
            state_in        = ST_RESPOND;
         end
         ST_PRELOAD: begin
            cmd.preload = 1'b1;
            state_in    = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/dmwbc_dpath.sv]
// Cache datapath: line index unit, line store with valid/dirty flops, backing
// store, statistics counters and response register. Uses dmwbc_pkg and dmwbc_ram.
`default_nettype none

module dmwbc_dpath #(
   parameter int ADDRESS_BITS = dmwbc_pkg::DEF_ADDRESS_BITS,
   parameter int LINE_COUNT   = dmwbc_pkg::DEF_LINE_COUNT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dmwbc_pkg::dp_cmd_type      cmd,
   output dmwbc_pkg::dp_status_type        status,
   input  wire dmwbc_pkg::req_payload_type req_payload,
   dmwbc_chan_if.source                    rsp_bus
);
   import dmwbc_pkg::*;

   localparam int DEPTH   = 1 << ADDRESS_BITS;
   localparam int MASK    = DEPTH - 1;
   localparam int IDX_W   = $clog2(LINE_COUNT);
   localparam int LC_W    = $clog2(LINE_COUNT + 1);
   localparam int EXT_W   = ADDRESS_BITS + LC_W;
   localparam int PROD_W  = ADDRESS_BITS + 32;
   localparam int LINE_W  = ADDRESS_BITS + WORD_BITS;
   // Reciprocal of the line count, rounded down; the quotient estimate is low
   // by at most one.
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / LINE_COUNT);
   // Reset image: line ln holds the highest address that maps to it.
   localparam int TOP_LN  = MASK % LINE_COUNT;
   localparam int BASE_HI = MASK - TOP_LN;
   localparam int BASE_LO = BASE_HI - LINE_COUNT;
   // With more lines than addresses, lines past the top address keep tag zero,
   // clean.
   localparam bit ALL_TOUCHED = (LINE_COUNT <= DEPTH);

   function automatic logic [ADDRESS_BITS-1:0] reset_tag(input logic [IDX_W-1:0] ln);
      if (int'(ln) <= TOP_LN) begin
         return ADDRESS_BITS'(BASE_HI) + ADDRESS_BITS'(ln);
      end
      if (!ALL_TOUCHED) begin
         return '0;
      end
      return ADDRESS_BITS'(BASE_LO) + ADDRESS_BITS'(ln);
   endfunction

   function automatic logic reset_dirty(input int ln);
      return ALL_TOUCHED || (ln <= TOP_LN);
   endfunction

   // Request fields.
   logic [1:0]              func_ff;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [WORD_BITS-1:0]    data_ff;

   // Index unit stages.
   logic [PROD_W-1:0]       prod_ff;
   logic [ADDRESS_BITS-1:0] qm_ff;
   logic [EXT_W-1:0]        qm_in;
   logic [ADDRESS_BITS-1:0] rem;
   logic [ADDRESS_BITS-1:0] rem_fixed;
   logic [IDX_W-1:0]        idx_ff;

   // Line state.
   logic [LINE_COUNT-1:0]   line_valid_ff;
   logic [LINE_COUNT-1:0]   line_dirty_ff;
   logic [LINE_W-1:0]       line_rd;
   logic [LINE_W-1:0]       line_wdata;
   logic                    line_we;
   logic [ADDRESS_BITS-1:0] cur_tag;
   logic [WORD_BITS-1:0]    cur_word;

   // Victim and lookup result.
   logic                    hit_ff;
   logic                    vdirty_ff;
   logic [ADDRESS_BITS-1:0] vtag_ff;
   logic [WORD_BITS-1:0]    vword_ff;
   logic [WORD_BITS-1:0]    rdata_ff;

   // Backing store port.
   logic [ADDRESS_BITS-1:0] clr_ff;
   logic [ADDRESS_BITS-1:0] bk_addr;
   logic [WORD_BITS-1:0]    bk_wdata;
   logic [WORD_BITS-1:0]    bk_rd;
   logic                    bk_we;

   // Counters and response.
   logic [COUNT_BITS-1:0]   hit_cnt_ff, miss_cnt_ff, fill_cnt_ff, wb_cnt_ff;
   logic [COUNT_BITS-1:0]   hit_cnt_in, miss_cnt_in, fill_cnt_in, wb_cnt_in;
   logic                    is_read, is_write, is_access;
   logic                    hit_out, wb_out, fill_out;
   rsp_payload_type         rsp_ff;
   logic                    rsp_valid_ff;

   // Capture the request on transfer.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_payload.func;
         addr_ff <= req_payload.access_address[ADDRESS_BITS-1:0];
         data_ff <= req_payload.write_data;
      end
   end

   // Line index = address modulo the line count: reciprocal multiply, scale
   // back, then one correcting subtract. Free-running through prod_ff, qm_ff and idx_ff.
   assign qm_in = EXT_W'(prod_ff[PROD_W-1:32]) * EXT_W'(LINE_COUNT);
   assign rem   = addr_ff - qm_ff;

   always_comb begin
      rem_fixed = rem;
      if (EXT_W'(rem) >= EXT_W'(LINE_COUNT)) begin
         rem_fixed = rem - ADDRESS_BITS'(LINE_COUNT);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(addr_ff) * PROD_W'(RECIP);
      qm_ff   <= qm_in[ADDRESS_BITS-1:0];
      idx_ff  <= IDX_W'(rem_fixed);
   end

   // Line store: tag and word in RAM, valid and dirty in flops.
   assign line_we    = cmd.line_fill || cmd.line_update;
   assign line_wdata = {addr_ff, cmd.line_fill ? bk_rd : data_ff};

   dmwbc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_COUNT)
   ) u_line_ram (
      .clock      (clock),
      .write_en   (line_we),
      .addr       (idx_ff),
      .write_data (line_wdata),
      .read_data  (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
         for (int i = 0; i < LINE_COUNT; i++) begin
            line_dirty_ff[i] <= reset_dirty(i);
         end
      end else if (line_we) begin
         line_valid_ff[idx_ff] <= 1'b1;
         line_dirty_ff[idx_ff] <= cmd.line_update;
      end
   end

   // A line never written since reset shows its reset image.
   assign cur_tag  = line_valid_ff[idx_ff] ? line_rd[LINE_W-1:WORD_BITS] : reset_tag(idx_ff);
   assign cur_word = line_valid_ff[idx_ff] ? line_rd[WORD_BITS-1:0] : '0;

   // Lookup result and victim.
   always_ff @(posedge clock) begin
      if (cmd.line_capture) begin
         hit_ff    <= (cur_tag == addr_ff);
         vdirty_ff <= line_dirty_ff[idx_ff];
         vtag_ff   <= cur_tag;
         vword_ff  <= cur_word;
      end
   end

   // Read data: the cached word on a hit, the fetched word on a fill.
   always_ff @(posedge clock) begin
      if (cmd.line_capture) begin
         rdata_ff <= cur_word;
      end else if (cmd.line_fill) begin
         rdata_ff <= bk_rd;
      end
   end

   // Backing store port selection.
   always_comb begin
      bk_addr  = addr_ff;
      bk_wdata = data_ff;
      if (cmd.clear_write) begin
         bk_addr  = clr_ff;
         bk_wdata = '0;
      end else if (cmd.backing_writeback) begin
         bk_addr  = vtag_ff;
         bk_wdata = vword_ff;
      end
   end

   assign bk_we = cmd.clear_write || cmd.backing_writeback || cmd.preload;

   dmwbc_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_backing_ram (
      .clock      (clock),
      .write_en   (bk_we),
      .addr       (bk_addr),
      .write_data (bk_wdata),
      .read_data  (bk_rd)
   );

   // Clearing pass address.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_ff <= clr_ff + ADDRESS_BITS'(1);
      end
   end

   // Result flags; the lookup registers are stale for non-access operations.
   assign is_read   = (func_ff == FUNC_READ);
   assign is_write  = (func_ff == FUNC_WRITE);
   assign is_access = is_read || is_write;
   assign hit_out   = is_access && hit_ff;
   assign wb_out    = is_access && !hit_ff && vdirty_ff;
   assign fill_out  = is_read && !hit_ff;

   assign hit_cnt_in  = sat_inc(hit_cnt_ff, is_read && hit_ff);
   assign miss_cnt_in = sat_inc(miss_cnt_ff, fill_out);
   assign fill_cnt_in = sat_inc(fill_cnt_ff, fill_out);
   assign wb_cnt_in   = sat_inc(wb_cnt_ff, wb_out);

   // Statistics counters advance as the response is formed.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         fill_cnt_ff <= '0;
         wb_cnt_ff   <= '0;
      end else if (cmd.respond) begin
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         fill_cnt_ff <= fill_cnt_in;
         wb_cnt_ff   <= wb_cnt_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.read_data           <= is_read ? rdata_ff : '0;
         rsp_ff.was_hit             <= hit_out;
         rsp_ff.did_writeback       <= wb_out;
         rsp_ff.writeback_address   <= wb_out ? WORD_BITS'(vtag_ff) : '0;
         rsp_ff.writeback_data      <= wb_out ? vword_ff : '0;
         rsp_ff.did_fill            <= fill_out;
         rsp_ff.hit_total           <= hit_cnt_in;
         rsp_ff.miss_total          <= miss_cnt_in;
         rsp_ff.backing_read_total  <= fill_cnt_in;
         rsp_ff.backing_write_total <= wb_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // Status to the controller.
   assign status.is_read      = is_read;
   assign status.is_write     = is_write;
   assign status.is_preload   = (func_ff == FUNC_PRELOAD);
   assign status.hit          = hit_ff;
   assign status.victim_dirty = vdirty_ff;
   assign status.word_differs = (vword_ff != data_ff);
   assign status.clear_done   = (clr_ff == ADDRESS_BITS'(MASK));
   assign status.rsp_free     = !rsp_valid_ff || rsp_bus.ready;

endmodule

`default_nettype wire

[src/direct_mapped_writeback_cache.sv]
// Top level of the direct-mapped write-back cache: controller plus datapath.
// Depends on dmwbc_pkg, dmwbc_chan_if, dmwbc_ctrl, dmwbc_dpath and dmwbc_ram.
//
//   channel   direction   carries
//   req_bus   in          func, access_address, write_data
//   rsp_bus   out         read data, hit/write-back/fill flags, victim, totals
//
// One request at a time: the next is accepted only after the previous one is
// loaded into the response register. A read or write passes the modulo unit
// and the registered line RAM read, then, as needed, a write-back and a fill
// or update; a preload or an unused code skips the lookup.
// After reset the backing store is swept to zero, one word a cycle, over all
// 2^ADDRESS_BITS addresses before the first request is taken. A stalled response
// holds in its output register; the next request is still taken and waits
// only at its own response.
`default_nettype none

module direct_mapped_writeback_cache #(
   parameter int ADDRESS_BITS = dmwbc_pkg::DEF_ADDRESS_BITS,
   parameter int LINE_COUNT   = dmwbc_pkg::DEF_LINE_COUNT
) (
   input wire logic     clock,
   input wire logic     reset,
   dmwbc_chan_if.sink   req_bus,
   dmwbc_chan_if.source rsp_bus
);
   import dmwbc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   dmwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, index unit, counters and response register.
   dmwbc_dpath #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .LINE_COUNT   (LINE_COUNT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_bus.payload),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire
